// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// request and result items, control codes and the cursor update bundle.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;
	localparam int LOC_W  = 11;
	localparam int CALC_W = COL_W + ROW_W + 1;

	// cell contents and control characters
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
	localparam logic [7:0]        SPACE_CHAR = 8'h20;
	localparam logic [7:0]        CH_NL      = 8'd10;
	localparam logic [7:0]        CH_TAB     = 8'd9;
	localparam logic [7:0]        CH_BS      = 8'd8;
	localparam int                TAB_STEP   = 8;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_SET   = 2'd2,
		REQ_READ  = 2'd3
	} req_e;

	typedef struct packed {
		req_e             req_type;
		logic [7:0]       char_code;
		logic [7:0]       color;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} req_t;

	typedef struct packed {
		logic [LOC_W-1:0]  cursor_location;
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
		logic [CELL_W-1:0] cell_data;
	} rsp_t;

	// cursor unit outcome for one item
	typedef struct packed {
		logic [COL_W-1:0]  new_col;
		logic [ROW_W-1:0]  new_row;
		logic              scroll;
		logic              clear;
		logic              wr_en;
		logic [COL_W-1:0]  wr_col;
		logic [CELL_W-1:0] wr_data;
		logic [COL_W-1:0]  rd_col;
		logic [ROW_W-1:0]  rd_row;
	} upd_t;

endpackage

// File: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor arithmetic for one item: control characters, line wrap, scroll
// detection, coordinate saturation and the cell write that a put causes.
// ----------------------------------------------------------------------------
module tcw_cursor (
	input  tcw_pkg::req_t                  request,
	input  logic [tcw_pkg::COL_W-1:0]      col,
	input  logic [tcw_pkg::ROW_W-1:0]      row,
	output tcw_pkg::upd_t                  upd
);

	import tcw_pkg::*;

	logic [COL_W:0] col_ext;
	logic [COL_W:0] tab_pos;
	logic [COL_W:0] put_col;
	logic           row_step;
	logic [ROW_W:0] put_row;
	logic [COL_W-1:0] sat_col;
	logic [ROW_W-1:0] sat_row;
	logic              wr_en;
	logic [COL_W-1:0]  wr_col;
	logic [CELL_W-1:0] wr_data;

	// saturated target coordinates
	always_comb begin
		if ({1'b0, request.column} >= (COL_W+1)'(COLUMNS)) begin
			sat_col = COL_W'(COLUMNS - 1);
		end else begin
			sat_col = request.column;
		end
		if ({1'b0, request.row} >= (ROW_W+1)'(ROWS)) begin
			sat_row = ROW_W'(ROWS - 1);
		end else begin
			sat_row = request.row;
		end
	end

	assign col_ext = {1'b0, col};
	assign tab_pos = (col_ext + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));

	// put character: column move, cell write and wrap
	always_comb begin
		put_col  = col_ext;
		row_step = 1'b0;
		wr_en    = 1'b0;
		wr_col   = col;
		wr_data  = {request.color, request.char_code};
		if (request.char_code == CH_NL) begin
			put_col  = '0;
			row_step = 1'b1;
		end else if (request.char_code == CH_TAB) begin
			put_col = tab_pos;
		end else if (request.char_code == CH_BS) begin
			if (col != '0) begin
				put_col = col_ext - 1'b1;
				wr_en   = request.req_type == REQ_PUT;
				wr_col  = col - 1'b1;
				wr_data = {request.color, SPACE_CHAR};
			end
		end else begin
			wr_en   = request.req_type == REQ_PUT;
			put_col = col_ext + 1'b1;
		end
		if (put_col >= (COL_W+1)'(COLUMNS)) begin
			put_col  = '0;
			row_step = 1'b1;
		end
		put_row = {1'b0, row} + (ROW_W+1)'(row_step);
	end

	// new cursor per request kind
	always_comb begin
		upd.new_col = col;
		upd.new_row = row;
		upd.scroll  = 1'b0;
		upd.clear   = 1'b0;
		upd.wr_en   = wr_en;
		upd.wr_col  = wr_col;
		upd.wr_data = wr_data;
		upd.rd_col  = sat_col;
		upd.rd_row  = sat_row;
		case (request.req_type)
			REQ_PUT: begin
				upd.new_col = put_col[COL_W-1:0];
				if (put_row >= (ROW_W+1)'(ROWS)) begin
					upd.scroll  = 1'b1;
					upd.new_row = ROW_W'(ROWS - 1);
				end else begin
					upd.new_row = put_row[ROW_W-1:0];
				end
			end
			REQ_CLEAR: begin
				upd.new_col = '0;
				upd.new_row = '0;
				upd.clear   = 1'b1;
			end
			REQ_SET: begin
				upd.new_col = sat_col;
				upd.new_row = sat_row;
			end
			default: begin
				upd.new_col = col;
				upd.new_row = row;
			end
		endcase
	end

endmodule

// File: rtl/core/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: screen buffer in one synchronous RAM with a rotating
// top-row offset, cursor registers, and a blanking sweep for scroll and clear.
// ----------------------------------------------------------------------------
// An accepted item passes through the exec and response states; the result
// strobe comes in the response state. Busy stays high until the sequencer is
// back in idle. A scroll then blanks the new last row through the single RAM
// write port; a clear blanks all ROWS*COLUMNS cells. After reset the same
// write port blanks all ROWS*COLUMNS cells with busy high. Results cannot be
// stalled: done is a one-cycle strobe.
module text_console_writer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tcw_pkg::req_t request,
	output logic          done,
	output tcw_pkg::rsp_t result
);

	import tcw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_SWEEP
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  top_q;
	logic              scrolled_q;
	logic              sweep_pend_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_last_q;

	upd_t              upd;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;
	logic [ROW_W-1:0]  top_next;
	logic [ADDR_W-1:0] top_base;
	logic [CALC_W-1:0] loc_full;

	// logical cell to RAM address through the top-row offset
	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [COL_W-1:0] c,
		input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] top
	);
		logic [ROW_W:0]    prow;
		logic [CALC_W-1:0] lin;
		prow = {1'b0, r} + {1'b0, top};
		if (prow >= (ROW_W+1)'(ROWS)) begin
			prow = prow - (ROW_W+1)'(ROWS);
		end
		lin = CALC_W'(prow) * CALC_W'(COLUMNS) + CALC_W'(c);
		return lin[ADDR_W-1:0];
	endfunction

	tcw_cursor u_cursor (
		.request (req_q),
		.col     (col_q),
		.row     (row_q),
		.upd     (upd)
	);

	// next top row and the old top row's base address for a scroll
	always_comb begin
		if ({1'b0, top_q} + 1'b1 >= (ROW_W+1)'(ROWS)) begin
			top_next = '0;
		end else begin
			top_next = top_q + 1'b1;
		end
		top_base = cell_addr('0, '0, top_q);
	end

	// ram port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(upd.wr_col, row_q, top_q);
		mem_wdata = upd.wr_data;
		mem_re    = 1'b0;
		mem_raddr = cell_addr(upd.rd_col, upd.rd_row, top_q);
		case (state_q)
			ST_EXEC: begin
				mem_we = upd.wr_en;
				mem_re = req_q.req_type == REQ_READ;
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_addr_q;
				mem_wdata = BLANK_CELL;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.DEPTH (CELLS),
		.WIDTH (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer, cursor and sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			col_q        <= '0;
			row_q        <= '0;
			top_q        <= '0;
			scrolled_q   <= 1'b0;
			sweep_pend_q <= 1'b0;
			sweep_addr_q <= '0;
			sweep_last_q <= ADDR_W'(CELLS - 1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					col_q        <= upd.new_col;
					row_q        <= upd.new_row;
					scrolled_q   <= upd.scroll;
					sweep_pend_q <= upd.scroll | upd.clear;
					if (upd.clear) begin
						top_q        <= '0;
						sweep_addr_q <= '0;
						sweep_last_q <= ADDR_W'(CELLS - 1);
					end else if (upd.scroll) begin
						top_q        <= top_next;
						sweep_addr_q <= top_base;
						sweep_last_q <= top_base + ADDR_W'(COLUMNS - 1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= sweep_pend_q ? ST_SWEEP : ST_IDLE;
				end
				ST_SWEEP: begin
					sweep_pend_q <= 1'b0;
					if (sweep_addr_q == sweep_last_q) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= request;
		end
	end

	// result item
	assign loc_full = CALC_W'(row_q) * CALC_W'(COLUMNS) + CALC_W'(col_q);
	assign busy     = state_q != ST_IDLE;
	assign done     = state_q == ST_RESP;

	always_comb begin
		result.cursor_location = loc_full[LOC_W-1:0];
		result.cursor_column   = col_q;
		result.cursor_row      = row_q;
		result.scrolled        = scrolled_q;
		result.cell_data       = (req_q.req_type == REQ_READ) ? mem_rdata : '0;
	end

endmodule

// File: rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer: result timing against the
// start handshake and cursor range on every result item.
// ----------------------------------------------------------------------------
module tcw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input tcw_pkg::rsp_t result
);

	import tcw_pkg::*;

	// an accepted item gives its result once the core has passed its exec state
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result strobe missing after accepted item");

	// results only appear while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// the strobe lasts one cycle per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// cursor always on screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, result.cursor_column} < (COL_W+1)'(COLUMNS)) &&
		         ({1'b0, result.cursor_row} < (ROW_W+1)'(ROWS)))
		else $error("cursor off screen");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: dv/tcw_console_monitor.sv
// ----------------------------------------------------------------------------
// tcw_console_monitor
// Watches the request and result channels of the text console writer. It
// keeps a shadow screen and cursor, works out the expected result of every
// accepted request item, and compares each result strobe, field by field,
// with the oldest expected result.
// ----------------------------------------------------------------------------
module tcw_console_monitor
	import tcw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  busy,
	input  req_t  request,
	input  logic  done,
	input  rsp_t  result,
	output int    fail_count,
	output int    open_count
);

	// shadow copy of the screen and the cursor
	logic [CELL_W-1:0] shadow_screen [CELLS];
	int                cur_col;
	int                cur_row;

	// results still to come, oldest first
	rsp_t rsp_due_q [$];
	rsp_t due_rsp;
	int   n_fail;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			shadow_screen[i] = BLANK_CELL;
	endfunction

	function automatic int clamp_to(input int v, input int lim);
		return (v >= lim) ? lim - 1 : v;
	endfunction

	// apply one request item to the shadow state and build its result
	function automatic rsp_t console_step(input req_t rq);
		rsp_t r;
		int   rd_col;
		int   rd_row;
		r = '0;
		case (rq.req_type)
			REQ_PUT: begin
				if (rq.char_code == CH_NL) begin
					cur_col = 0;
					cur_row++;
				end else if (rq.char_code == CH_TAB) begin
					cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
				end else if (rq.char_code == CH_BS) begin
					// backspace erases the previous cell, nothing at column 0
					if (cur_col > 0) begin
						cur_col--;
						shadow_screen[cur_row * COLUMNS + cur_col] = {rq.color, SPACE_CHAR};
					end
				end else begin
					shadow_screen[cur_row * COLUMNS + cur_col] = {rq.color, rq.char_code};
					cur_col++;
				end
				// line wrap
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				// scroll up one line and blank the last row
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
						shadow_screen[i] = BLANK_CELL;
					cur_row = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			REQ_CLEAR: begin
				blank_screen();
				cur_col = 0;
				cur_row = 0;
			end
			REQ_SET: begin
				cur_col = clamp_to(int'(rq.column), COLUMNS);
				cur_row = clamp_to(int'(rq.row), ROWS);
			end
			default: begin
				rd_col = clamp_to(int'(rq.column), COLUMNS);
				rd_row = clamp_to(int'(rq.row), ROWS);
				r.cell_data = shadow_screen[rd_row * COLUMNS + rd_col];
			end
		endcase
		r.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
		r.cursor_column   = COL_W'(cur_col);
		r.cursor_row      = ROW_W'(cur_row);
		return r;
	endfunction

	// compare results first, then record the item accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_screen();
			cur_col = 0;
			cur_row = 0;
			rsp_due_q.delete();
			n_fail = 0;
			fail_count <= 0;
			open_count <= 0;
		end else begin
			if (done) begin
				if (rsp_due_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 40)
						$display("%0t: result with no item outstanding: loc %0d col %0d row %0d scr %0b data %h",
							$time, result.cursor_location, result.cursor_column,
							result.cursor_row, result.scrolled, result.cell_data);
				end else begin
					due_rsp = rsp_due_q.pop_front();
					if (result !== due_rsp) begin
						n_fail++;
						if (n_fail <= 40)
							$display("%0t: result mismatch: expected loc %0d col %0d row %0d scr %0b data %h, actual loc %0d col %0d row %0d scr %0b data %h",
								$time, due_rsp.cursor_location, due_rsp.cursor_column,
								due_rsp.cursor_row, due_rsp.scrolled, due_rsp.cell_data,
								result.cursor_location, result.cursor_column,
								result.cursor_row, result.scrolled, result.cell_data);
					end
				end
			end
			if (start && !busy)
				rsp_due_q.push_back(console_step(request));
			fail_count <= n_fail;
			open_count <= rsp_due_q.size();
		end
	end

endmodule

// File: dv/text_console_writer_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Drives request items into the text console writer: a directed opening over
// control codes, wrap, scroll, saturation and clear, then random traffic with
// random sender gaps. Results are checked by the console monitor.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
	import tcw_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;
	int   fail_count;
	int   open_count;

	// sender pacing: burst stretches with no gaps are mixed at random with gappy ones
	bit   burst_mode;

	text_console_writer_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	tcw_console_monitor u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// present one item, hold it until accepted, then maybe idle
	task automatic issue(input req_e kind, input logic [7:0] ch, input logic [7:0] attr,
			input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
		int gap;
		int pick;
		start   <= 1'b1;
		request <= '{kind, ch, attr, c, r};
		do @(posedge clk); while (busy);
		pick = $urandom_range(0, 99);
		if (burst_mode || pick < 45)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
	endtask

	initial begin
		int          sel;
		int          k;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
		req_e        kind;

		arst_n     = 1'b0;
		start     <= 1'b0;
		request   <= '0;
		burst_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		issue(REQ_READ,  8'h00, 8'h00, 7'd0,   5'd0);
		issue(REQ_PUT,   8'h41, 8'hFF, 7'd0,   5'd0);
		issue(REQ_PUT,   8'h00, 8'h00, 7'd0,   5'd0);
		issue(REQ_PUT,   8'd13, 8'h1E, 7'd0,   5'd0);
		issue(REQ_PUT,   8'hFF, 8'h80, 7'd0,   5'd0);
		issue(REQ_PUT,   CH_BS, 8'h4F, 7'd0,   5'd0);
		issue(REQ_PUT,   CH_TAB, 8'h00, 7'd0,  5'd0);
		issue(REQ_READ,  8'h00, 8'h00, 7'd3,   5'd0);
		issue(REQ_SET,   8'h00, 8'h00, 7'd0,   5'd0);
		issue(REQ_PUT,   CH_BS, 8'h70, 7'd0,   5'd0);
		issue(REQ_SET,   8'h00, 8'h00, 7'd75,  5'd3);
		issue(REQ_PUT,   CH_TAB, 8'h07, 7'd0,  5'd0);
		issue(REQ_SET,   8'h00, 8'h00, 7'd79,  5'd5);
		issue(REQ_PUT,   8'h7A, 8'h2A, 7'd0,   5'd0);
		issue(REQ_SET,   8'h00, 8'h00, 7'd127, 5'd31);
		issue(REQ_PUT,   8'h78, 8'hC3, 7'd0,   5'd0);
		issue(REQ_SET,   8'h00, 8'h00, 7'd5,   5'd24);
		issue(REQ_PUT,   CH_NL, 8'h00, 7'd0,   5'd0);
		issue(REQ_READ,  8'h00, 8'h00, 7'd127, 5'd31);
		issue(REQ_READ,  8'h00, 8'h00, 7'd79,  5'd23);
		issue(REQ_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31);
		issue(REQ_READ,  8'h00, 8'h00, 7'd79,  5'd23);
		drain();

		// random traffic
		for (int i = 0; i < 2000; i++) begin
			if (i % 100 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			if (i % 250 == 249)
				drain();
			sel  = $urandom_range(0, 999);
			ch   = 8'($urandom);
			attr = 8'($urandom);
			c    = COL_W'($urandom);
			r    = ROW_W'($urandom);
			if (sel < 12) begin
				kind = REQ_CLEAR;
			end else if (sel < 150) begin
				// set cursor, often near the right edge or bottom rows
				kind = REQ_SET;
				if ($urandom_range(0, 1))
					r = ROW_W'($urandom_range(20, 31));
				if ($urandom_range(0, 1))
					c = COL_W'($urandom_range(70, 127));
			end else if (sel < 330) begin
				kind = REQ_READ;
				if ($urandom_range(0, 1))
					r = ROW_W'($urandom_range(20, 24));
			end else begin
				// put character: mostly printable, plus control codes
				kind = REQ_PUT;
				k = $urandom_range(0, 99);
				if (k < 10)
					ch = CH_NL;
				else if (k < 18)
					ch = CH_TAB;
				else if (k < 28)
					ch = CH_BS;
				else if (k < 80)
					ch = 8'($urandom_range(32, 126));
			end
			issue(kind, ch, attr, c, r);
		end

		// wind down
		drain();
		repeat (2100) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_cursor.sv
rtl/core/text_console_writer_core.sv
rtl/core/tcw_checker.sv
dv/tcw_console_monitor.sv
dv/text_console_writer_core_tb.sv
